// File: design/nspt_pkg.sv
`default_nettype none
package nspt_pkg;

	localparam int HISTORY_DEPTH_DEF = 64;
	localparam int TIME_BITS_DEF     = 48;
	localparam int ENTRY_BITS_DEF    = 32;
	localparam int TOT_ENTRY_W       = 48;
	localparam int CNT_W             = 7;
	localparam int DEN_W             = 8;
	localparam int DEPTH_W           = 8;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_END   = 2'd1,
		CMD_FRAME = 2'd2,
		CMD_RESET = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SEL_TIME   = 2'd0,
		SEL_NESTED = 2'd1,
		SEL_ENTRY  = 2'd2
	} sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_DRAIN,
		ST_DIVS,
		ST_DIVW,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

endpackage
`default_nettype wire

// File: design/nspt_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module nspt_div #(
	parameter int NW = 63
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [NW-1:0]             num,
	input  wire logic [nspt_pkg::DEN_W-1:0] den,
	output logic      [NW-1:0]             quo,
	output logic                           done
);
	import nspt_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [NW-1:0]     acc_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    trial;
	logic              ge;
	logic [DEN_W-1:0]  rem_n;

	always_comb begin
		trial = {rem_q, acc_q[NW-1]};
		ge    = trial >= {1'b0, den};
		rem_n = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[NW-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign quo  = acc_q;
	assign done = done_q;

endmodule
`default_nettype wire

// File: design/nested_scope_timing_profiler_core.sv
`default_nettype none
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall   | command, timestamp
// out     | output    | out_valid/out_stall | frame/total/avg/max figures
// cfg     | input     | cfg_wr_en           | cfg_wr_data (history size)
//
// The history scan reads one entry per cycle, then one shared bit-serial divider
// (NW = max(TIME_BITS, ENTRY_BITS)+15 bits wide) forms the three averages.
// in_stall is high from acceptance until the result word is taken.
// Reset clears all counters; history memory content is not cleared.
module nested_scope_timing_profiler_core #(
	parameter int TIME_BITS     = nspt_pkg::TIME_BITS_DEF,
	parameter int ENTRY_BITS    = nspt_pkg::ENTRY_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [nspt_pkg::CNT_W-1:0]        cfg_wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        command,
	input  wire logic [TIME_BITS-1:0]              timestamp,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [TIME_BITS-1:0]                   frame_time,
	output logic [TIME_BITS-1:0]                   nested_frame_time,
	output logic [ENTRY_BITS-1:0]                  frame_entries,
	output logic [TIME_BITS-1:0]                   total_time,
	output logic [TIME_BITS-1:0]                   total_nested_time,
	output logic [nspt_pkg::TOT_ENTRY_W-1:0]       total_entries,
	output logic [TIME_BITS+7:0]                   avg_frame_time,
	output logic [TIME_BITS+7:0]                   avg_nested_time,
	output logic [ENTRY_BITS+7:0]                  avg_entries,
	output logic [TIME_BITS-1:0]                   max_frame_time,
	output logic [TIME_BITS-1:0]                   max_nested_time,
	output logic [ENTRY_BITS-1:0]                  max_entries
);
	import nspt_pkg::*;

	localparam int HISTORY_DEPTH = HISTORY_DEPTH_DEF;
	localparam int TW = TIME_BITS;
	localparam int EW = ENTRY_BITS;
	localparam int VW = (TW > EW) ? TW : EW;
	localparam int SW = VW + CNT_W;
	localparam int NW = SW + 8;
	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	state_t state_q, state_n;

	logic [CNT_W-1:0]       size_q;
	logic [CNT_W-1:0]       count_q;
	logic [AW-1:0]          head_q;
	logic [DEPTH_W-1:0]     depth_q;
	logic [TW-1:0]          last_q;
	logic [TW-1:0]          cur_ft_q, cur_nt_q, sum_t_q, sum_nt_q;
	logic [EW-1:0]          cur_en_q;
	logic [TOT_ENTRY_W-1:0] sum_en_q;

	logic [TW-1:0] hist_ft [HISTORY_DEPTH];
	logic [TW-1:0] hist_nt [HISTORY_DEPTH];
	logic [EW-1:0] hist_en [HISTORY_DEPTH];
	logic [TW-1:0] rd_ft_q, rd_nt_q;
	logic [EW-1:0] rd_en_q;
	logic          rd_vld_q;
	logic [CNT_W-1:0] idx_q;

	logic [SW-1:0] acc_ft_q, acc_nt_q, acc_en_q;
	logic [TW-1:0] mx_ft_q, mx_nt_q;
	logic [EW-1:0] mx_en_q;
	logic [TW+7:0] avg_ft_q, avg_nt_q;
	logic [EW+7:0] avg_en_q;
	logic [1:0]    sel_q;

	logic              div_start;
	logic              div_done;
	logic [NW-1:0]     div_num, div_quo;
	logic [DEN_W-1:0]  div_den;

	logic          accept;
	logic [TW-1:0] dt;
	logic [TW:0]   add_nt, add_snt, add_ft, add_st;
	logic [EW:0]   add_en;
	logic [TOT_ENTRY_W:0] add_sen;
	logic [DEPTH_W-1:0]   depth_up;
	logic [CNT_W-1:0]     head_nx;
	logic                 frame_wr;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign dt       = timestamp - last_q;
	assign depth_up = (depth_q == '1) ? depth_q : depth_q + DEPTH_W'(1);
	assign add_nt   = {1'b0, cur_nt_q} + {1'b0, dt};
	assign add_snt  = {1'b0, sum_nt_q} + {1'b0, dt};
	assign add_ft   = {1'b0, cur_ft_q} + {1'b0, dt};
	assign add_st   = {1'b0, sum_t_q} + {1'b0, dt};
	assign add_en   = {1'b0, cur_en_q} + (EW + 1)'(1);
	assign add_sen  = {1'b0, sum_en_q} + (TOT_ENTRY_W + 1)'(1);
	assign head_nx  = CNT_W'(head_q) + CNT_W'(1);
	assign frame_wr = accept && (command == CMD_FRAME) && (size_q != '0);

	// event and configuration update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= '0;
			count_q  <= '0;
			head_q   <= '0;
			depth_q  <= '0;
			last_q   <= '0;
			cur_ft_q <= '0;
			cur_nt_q <= '0;
			cur_en_q <= '0;
			sum_t_q  <= '0;
			sum_nt_q <= '0;
			sum_en_q <= '0;
		end else if (cfg_wr_en) begin
			size_q  <= (cfg_wr_data > HISTORY_DEPTH) ? CNT_W'(HISTORY_DEPTH) : cfg_wr_data;
			count_q <= '0;
			head_q  <= '0;
		end else if (accept) begin
			case (command)
				CMD_BEGIN: begin
					depth_q  <= depth_up;
					cur_en_q <= add_en[EW] ? '1 : add_en[EW-1:0];
					sum_en_q <= add_sen[TOT_ENTRY_W] ? '1 : add_sen[TOT_ENTRY_W-1:0];
					if (depth_up != DEPTH_W'(1)) begin
						cur_nt_q <= add_nt[TW] ? '1 : add_nt[TW-1:0];
						sum_nt_q <= add_snt[TW] ? '1 : add_snt[TW-1:0];
					end
					last_q <= timestamp;
				end
				CMD_END: begin
					if (depth_q != '0) begin
						depth_q  <= depth_q - DEPTH_W'(1);
						cur_ft_q <= add_ft[TW] ? '1 : add_ft[TW-1:0];
						sum_t_q  <= add_st[TW] ? '1 : add_st[TW-1:0];
						if (depth_q != DEPTH_W'(1))
							last_q <= timestamp;
					end
				end
				CMD_FRAME: begin
					if (size_q != '0) begin
						if (count_q < size_q)
							count_q <= count_q + CNT_W'(1);
						head_q <= (head_nx >= size_q) ? '0 : AW'(head_nx);
					end
					cur_ft_q <= '0;
					cur_nt_q <= '0;
					cur_en_q <= '0;
				end
				default: begin
					cur_ft_q <= '0;
					cur_nt_q <= '0;
					cur_en_q <= '0;
					sum_t_q  <= '0;
					sum_nt_q <= '0;
					sum_en_q <= '0;
					count_q  <= '0;
					head_q   <= '0;
				end
			endcase
		end
	end

	// history memory: write at head, one read per scan cycle
	always_ff @(posedge clk) begin
		if (frame_wr) begin
			hist_ft[head_q] <= cur_ft_q;
			hist_nt[head_q] <= cur_nt_q;
			hist_en[head_q] <= cur_en_q;
		end
		rd_ft_q <= hist_ft[AW'(idx_q)];
		rd_nt_q <= hist_nt[AW'(idx_q)];
		rd_en_q <= hist_en[AW'(idx_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE:  if (accept) state_n = ST_INIT;
			ST_INIT:  state_n = (count_q == '0) ? ST_DIVS : ST_SCAN;
			ST_SCAN:  if (idx_q == count_q - CNT_W'(1)) state_n = ST_DRAIN;
			ST_DRAIN: state_n = ST_DIVS;
			ST_DIVS: begin
				div_start = 1'b1;
				state_n   = ST_DIVW;
			end
			ST_DIVW:  if (div_done) state_n = (sel_q == SEL_ENTRY) ? ST_OUT : ST_DIVS;
			ST_OUT:   if (!out_stall) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
			sel_q    <= SEL_TIME;
		end else begin
			rd_vld_q <= (state_q == ST_SCAN);
			if (state_q == ST_INIT) begin
				idx_q <= '0;
				sel_q <= SEL_TIME;
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (state_q == ST_DIVW && div_done)
				sel_q <= sel_q + 2'd1;
		end
	end

	// sums and maxima over current frame plus filled history; averages latched from the divider
	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			acc_ft_q <= SW'(cur_ft_q);
			acc_nt_q <= SW'(cur_nt_q);
			acc_en_q <= SW'(cur_en_q);
			mx_ft_q  <= cur_ft_q;
			mx_nt_q  <= cur_nt_q;
			mx_en_q  <= cur_en_q;
		end else if (rd_vld_q) begin
			acc_ft_q <= acc_ft_q + SW'(rd_ft_q);
			acc_nt_q <= acc_nt_q + SW'(rd_nt_q);
			acc_en_q <= acc_en_q + SW'(rd_en_q);
			if (rd_ft_q > mx_ft_q) mx_ft_q <= rd_ft_q;
			if (rd_nt_q > mx_nt_q) mx_nt_q <= rd_nt_q;
			if (rd_en_q > mx_en_q) mx_en_q <= rd_en_q;
		end
		if (state_q == ST_DIVW && div_done) begin
			case (sel_q)
				SEL_TIME:   avg_ft_q <= div_quo[TW+7:0];
				SEL_NESTED: avg_nt_q <= div_quo[TW+7:0];
				default:    avg_en_q <= div_quo[EW+7:0];
			endcase
		end
	end

	always_comb begin
		case (sel_q)
			SEL_TIME:   div_num = {acc_ft_q, 8'h00};
			SEL_NESTED: div_num = {acc_nt_q, 8'h00};
			default:    div_num = {acc_en_q, 8'h00};
		endcase
		div_den = {1'b0, count_q} + DEN_W'(1);
	end

	nspt_div #(.NW(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	assign out_valid         = (state_q == ST_OUT);
	assign frame_time        = cur_ft_q;
	assign nested_frame_time = cur_nt_q;
	assign frame_entries     = cur_en_q;
	assign total_time        = sum_t_q;
	assign total_nested_time = sum_nt_q;
	assign total_entries     = sum_en_q;
	assign avg_frame_time    = avg_ft_q;
	assign avg_nested_time   = avg_nt_q;
	assign avg_entries       = avg_en_q;
	assign max_frame_time    = mx_ft_q;
	assign max_nested_time   = mx_nt_q;
	assign max_entries       = mx_en_q;

endmodule
`default_nettype wire

// File: design/nspt_checker.sv
`default_nettype none
module nspt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("no stall after accepted word");

	a_stall_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result repeated");

endmodule

bind nested_scope_timing_profiler_core nspt_checker u_nspt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall)
);
`default_nettype wire
